### rtl/hcbp_pkg.sv
// Shared constants and types of the Huffman code bit packer.
package hcbp_pkg;

	// Default sizes of the packer.
	localparam int WORD_BITS_DEF   = 32;
	localparam int TABLE_DEPTH_DEF = 256;

	// Longest code word that the table can hold.
	localparam int MAX_CODE_BITS = 32;

	// Field widths of the items.
	localparam int OP_W     = 2;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_WORD_W = 32;
	localparam int CNT_W      = 6;
	localparam int OUT_DATA_W = 40;

	// Item kinds carried in the input tuser.
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

	// One code table entry.
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} entry_t;

endpackage

### rtl/huffman_code_bit_packer.sv
// Huffman code bit packer: code table memory, lookup stage and word accumulator.
//
// Input channel s_*: s_tuser carries the item kind (load, encode, flush) and
// s_tdata the symbol, code word and code length. A load item writes one table
// entry, an encode item appends the code of its symbol to the accumulator,
// most significant code bit first, and a flush item emits the pending bits.
// Output channel m_*: one item per full word of WORD_BITS bits, and one per
// flush that finds pending bits, right-aligned and marked with m_tlast.
// Throughput is one item per cycle while the receiver does not stall: the
// table is one memory with a single write port and a registered read port,
// and each encode is applied to the accumulator with a left and a right shift
// as it leaves the lookup stage. The table is read into the lookup stage at
// the accepting edge; the accumulator and output register load as it leaves.
// At reset the accumulator empties and every table entry reads as absent
// (length zero) through one valid flag per entry, so no clearing pass runs.
// When the receiver stalls with a result waiting, the lookup stage holds one
// more item and s_tready drops until the output register frees up.
module huffman_code_bit_packer #(
	parameter int WORD_BITS   = hcbp_pkg::WORD_BITS_DEF,
	parameter int TABLE_DEPTH = hcbp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// symbol [7:0], code_value [39:8], code_length [45:40], zero [47:46]
	input  logic [hcbp_pkg::IN_DATA_W-1:0]    s_tdata,
	// op [1:0]
	input  logic [hcbp_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// packed_word [31:0], bit_count [37:32], zero [39:38]
	output logic [hcbp_pkg::OUT_DATA_W-1:0]   m_tdata,
	// is_final
	output logic                              m_tlast
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int FW  = $clog2(WORD_BITS);
	localparam int CW  = WORD_BITS + hcbp_pkg::MAX_CODE_BITS;
	localparam int TW  = $clog2(CW + 1);
	localparam int CAP = (hcbp_pkg::MAX_CODE_BITS < WORD_BITS) ?
		hcbp_pkg::MAX_CODE_BITS : WORD_BITS;

	// Input fields.
	logic [hcbp_pkg::SYM_W-1:0]  in_sym;
	logic [hcbp_pkg::CODE_W-1:0] in_code;
	logic [hcbp_pkg::LEN_W-1:0]  in_len;
	logic                        in_take;
	logic                        in_range;
	logic [AW-1:0]               in_addr;
	logic [hcbp_pkg::LEN_W-1:0]  len_sat;
	logic [hcbp_pkg::CODE_W-1:0] load_mask;
	hcbp_pkg::entry_t            wr_entry;

	assign in_sym   = s_tdata[7:0];
	assign in_code  = s_tdata[39:8];
	assign in_len   = s_tdata[45:40];
	assign in_take  = s_tvalid && s_tready;
	assign in_range = ({1'b0, in_sym} < 9'(TABLE_DEPTH));
	assign in_addr  = in_sym[AW-1:0];

	// Saturate the loaded length and drop code bits above it.
	always_comb begin
		len_sat   = (in_len > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP) : in_len;
		load_mask = hcbp_pkg::CODE_W'((33'(1) << len_sat) - 33'(1));
		wr_entry.len  = len_sat;
		wr_entry.code = in_code & load_mask;
	end

	// Code table memory with a registered read port.
	hcbp_pkg::entry_t table_mem [TABLE_DEPTH];
	hcbp_pkg::entry_t rd_s1;
	logic             wr_en;

	assign wr_en = in_take && (s_tuser == hcbp_pkg::OP_LOAD) && in_range;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[in_addr] <= wr_entry;
		end
		if (in_take) begin
			rd_s1 <= table_mem[in_addr];
		end
	end

	// One valid flag per entry: an entry never loaded reads as absent.
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   evld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[in_addr] <= 1'b1;
		end
	end

	// Lookup stage control.
	logic                       valid_s1;
	logic [hcbp_pkg::OP_W-1:0]  op_s1;
	logic                       range_s1;
	logic                       s1_adv;
	logic                       out_vld_q;

	assign s1_adv   = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= s_tuser;
			range_s1 <= in_range;
			evld_s1  <= vld_q[in_addr];
		end
	end

	// Accumulator update with one left shift and one right shift.
	logic [WORD_BITS-1:0]       acc_q;
	logic [FW-1:0]              fill_q;
	logic [hcbp_pkg::LEN_W-1:0] cur_len;
	logic [CW-1:0]              comb;
	logic [CW-1:0]              shifted;
	logic [CW-1:0]              rest_mask;
	logic [TW-1:0]              total;
	logic [TW-1:0]              rest;
	logic                       enc_act;
	logic                       enc_emit;
	logic                       fl_emit;
	logic                       s1_emit;

	always_comb begin
		cur_len   = evld_s1 ? rd_s1.len : '0;
		comb      = (CW'(acc_q) << cur_len) | CW'(rd_s1.code);
		total     = TW'(fill_q) + TW'(cur_len);
		rest      = total - TW'(WORD_BITS);
		shifted   = comb >> rest;
		rest_mask = (CW'(1) << rest) - CW'(1);
		enc_act   = s1_adv && (op_s1 == hcbp_pkg::OP_ENCODE) && range_s1 &&
			(cur_len != '0);
		enc_emit  = enc_act && (total >= TW'(WORD_BITS));
		fl_emit   = s1_adv && (op_s1 == hcbp_pkg::OP_FLUSH) && (fill_q != '0);
		s1_emit   = enc_emit || fl_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (enc_emit) begin
			acc_q  <= WORD_BITS'(comb & rest_mask);
			fill_q <= FW'(rest);
		end else if (enc_act) begin
			acc_q  <= WORD_BITS'(comb);
			fill_q <= FW'(total);
		end else if (fl_emit) begin
			acc_q  <= '0;
			fill_q <= '0;
		end
	end

	// Output register.
	logic [hcbp_pkg::OUT_WORD_W-1:0] out_word_q;
	logic [hcbp_pkg::CNT_W-1:0]      out_cnt_q;
	logic                            out_fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_emit) begin
			out_word_q <= hcbp_pkg::OUT_WORD_W'(shifted[WORD_BITS-1:0]);
			out_cnt_q  <= hcbp_pkg::CNT_W'(WORD_BITS);
			out_fin_q  <= 1'b0;
		end else if (fl_emit) begin
			out_word_q <= hcbp_pkg::OUT_WORD_W'(acc_q);
			out_cnt_q  <= hcbp_pkg::CNT_W'(fill_q);
			out_fin_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_word_q};
	assign m_tlast  = out_fin_q;

	// A stalled input side means both the lookup stage and the output are full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_vld_q && !m_tready))
		else $error("input stalled without a full pipeline");

	// A completed word or a flush with pending bits shows up at the output.
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_emit |=> (out_vld_q && (out_fin_q == $past(fl_emit))))
		else $error("result did not reach the output register");

	// A flushed item always carries at least one bit.
	a_flush_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_fin_q) |-> (out_cnt_q != '0))
		else $error("flush result with no bits");

	// A flush leaves the accumulator empty.
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (op_s1 == hcbp_pkg::OP_FLUSH)) |=> (fill_q == '0 && acc_q == '0))
		else $error("accumulator not cleared by flush");

endmodule

### verif/tb_top.sv
// Self-checking testbench of the Huffman code bit packer: directed and random stream items.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD        = hcbp_pkg::WORD_BITS_DEF;
	localparam int TABLE_DEPTH = hcbp_pkg::TABLE_DEPTH_DEF;
	localparam int CODE_CAP    = (hcbp_pkg::MAX_CODE_BITS < WORD) ?
		hcbp_pkg::MAX_CODE_BITS : WORD;
	localparam logic [hcbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 20;

	// One stream item waiting to be driven.
	typedef struct {
		logic [hcbp_pkg::OP_W-1:0]   op;
		logic [hcbp_pkg::SYM_W-1:0]  sym;
		logic [hcbp_pkg::CODE_W-1:0] code;
		logic [hcbp_pkg::LEN_W-1:0]  len;
		bit                          hold;
	} code_op_t;

	// One output word that the packer must produce.
	typedef struct {
		logic [hcbp_pkg::OUT_WORD_W-1:0] word;
		logic [hcbp_pkg::CNT_W-1:0]      count;
		logic                            last;
	} packed_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [hcbp_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [hcbp_pkg::OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [hcbp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;

	code_op_t code_ops[$];
	packed_word_t words_due[$];
	logic [hcbp_pkg::SYM_W-1:0] loaded_syms[$];

	// Predicted state of the packer.
	logic [hcbp_pkg::CODE_W-1:0] code_tab[TABLE_DEPTH];
	int unsigned len_tab[TABLE_DEPTH];
	logic [63:0] acc_bits;
	int unsigned acc_fill;

	int errors = 0;
	int items_total = 0;
	int items_sent = 0;
	int items_taken = 0;
	int n_load = 0, n_encode = 0, n_flush = 0, n_unused = 0;
	int n_full = 0, n_partial = 0;
	int tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;

	huffman_code_bit_packer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] low_bits(input int unsigned n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Code lengths as a real code table would have them, with some out of range.
	function automatic logic [hcbp_pkg::LEN_W-1:0] draw_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 75)
			return hcbp_pkg::LEN_W'($urandom_range(1, 12));
		if (r < 90)
			return hcbp_pkg::LEN_W'($urandom_range(13, 32));
		return hcbp_pkg::LEN_W'($urandom_range(33, 63));
	endfunction

	function automatic void add_item(input logic [hcbp_pkg::OP_W-1:0] op,
			input logic [hcbp_pkg::SYM_W-1:0] sym, input logic [hcbp_pkg::CODE_W-1:0] code,
			input logic [hcbp_pkg::LEN_W-1:0] len, input bit hold);
		code_op_t it;
		it.op = op;
		it.sym = sym;
		it.code = code;
		it.len = len;
		it.hold = hold;
		code_ops.push_back(it);
		items_total++;
		if (op == hcbp_pkg::OP_LOAD)
			loaded_syms.push_back(sym);
	endfunction

	// Apply one accepted item to the predicted state and queue the word it yields.
	function automatic void pack_code(input logic [hcbp_pkg::OP_W-1:0] op,
			input logic [hcbp_pkg::SYM_W-1:0] sym, input logic [hcbp_pkg::CODE_W-1:0] code,
			input logic [hcbp_pkg::LEN_W-1:0] len);
		int unsigned l, total, room, rest;
		logic [63:0] c, w;
		packed_word_t r;
		case (op)
			hcbp_pkg::OP_LOAD: begin
				n_load++;
				if (int'(sym) < TABLE_DEPTH) begin
					l = len;
					if (l > CODE_CAP)
						l = CODE_CAP;
					len_tab[sym] = l;
					code_tab[sym] = hcbp_pkg::CODE_W'(64'(code) & low_bits(l));
				end
			end
			hcbp_pkg::OP_ENCODE: begin
				n_encode++;
				if (int'(sym) < TABLE_DEPTH && len_tab[sym] != 0) begin
					l = len_tab[sym];
					c = 64'(code_tab[sym]);
					total = acc_fill + l;
					if (total < WORD) begin
						acc_bits = ((acc_bits << l) | c) & low_bits(WORD);
						acc_fill = total;
					end else begin
						room = WORD - acc_fill;
						rest = total - WORD;
						w = ((acc_bits << room) | (c >> rest)) & low_bits(WORD);
						acc_bits = c & low_bits(rest);
						acc_fill = rest;
						r.word = w[hcbp_pkg::OUT_WORD_W-1:0];
						r.count = hcbp_pkg::CNT_W'(WORD);
						r.last = 1'b0;
						words_due.push_back(r);
					end
				end
			end
			hcbp_pkg::OP_FLUSH: begin
				n_flush++;
				if (acc_fill != 0) begin
					r.word = acc_bits[hcbp_pkg::OUT_WORD_W-1:0];
					r.count = hcbp_pkg::CNT_W'(acc_fill);
					r.last = 1'b1;
					words_due.push_back(r);
					acc_bits = '0;
					acc_fill = 0;
				end
			end
			default: n_unused++;
		endcase
	endfunction

	// Driver: presents queued items with random gaps, holding each until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (!(s_tvalid && !s_tready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (code_ops.size() != 0 && !(code_ops[0].hold &&
						(words_due.size() != 0 || items_taken != items_sent))) begin
					code_op_t it;
					it = code_ops.pop_front();
					items_sent++;
					s_tvalid <= 1'b1;
					s_tuser <= it.op;
					s_tdata <= {2'b00, it.len, it.code, it.sym};
					if (tx_calm > 0) begin
						tx_calm--;
						tx_gap = 0;
					end else if ($urandom_range(0, 49) == 0) begin
						tx_calm = $urandom_range(30, 80);
						tx_gap = 0;
					end else begin
						tx_gap = draw_idle();
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts each accepted item, checks each accepted word, stalls the output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				code_tab[k] = '0;
				len_tab[k] = 0;
			end
			acc_bits = '0;
			acc_fill = 0;
			words_due.delete();
			m_tready <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pack_code(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[45:40]);
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (words_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h count %0d last %0b", $time,
						m_tdata[31:0], m_tdata[37:32], m_tlast);
				end else begin
					packed_word_t e;
					e = words_due.pop_front();
					if (e.last)
						n_partial++;
					else
						n_full++;
					if (m_tdata[31:0] !== e.word) begin
						errors++;
						$display("%0t: packed_word expected %h actual %h", $time,
							e.word, m_tdata[31:0]);
					end
					if (m_tdata[37:32] !== e.count) begin
						errors++;
						$display("%0t: bit_count expected %0d actual %0d", $time,
							e.count, m_tdata[37:32]);
					end
					if (m_tlast !== e.last) begin
						errors++;
						$display("%0t: is_final expected %0b actual %0b", $time,
							e.last, m_tlast);
					end
				end
			end
			if (rx_stall == 0) begin
				if (rx_calm > 0)
					rx_calm--;
				else if ($urandom_range(0, 49) == 0)
					rx_calm = $urandom_range(30, 80);
				else
					rx_stall = draw_idle();
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int r;
		logic [hcbp_pkg::SYM_W-1:0] s;

		// Absent symbol, empty flush and an ignored op on a fresh table.
		add_item(hcbp_pkg::OP_ENCODE, 8'h05, '0, '0, 0);
		add_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0, 0);
		add_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0);
		// Zero-length entry adds no bits.
		add_item(hcbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h00, '0, '0, 0);
		add_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0, 0);
		// A full-width code fills a word in one item.
		add_item(hcbp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'hFF, '0, '0, 0);
		// Long lengths saturate, and bits above the length are dropped.
		add_item(hcbp_pkg::OP_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd63, 0);
		add_item(hcbp_pkg::OP_LOAD, 8'h02, 32'hFFFF_FFFF, 6'd1, 0);
		add_item(hcbp_pkg::OP_LOAD, 8'h03, 32'h0000_0005, 6'd3, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h02, '0, '0, 0);
		add_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0, 0);
		// A code that straddles the word boundary.
		add_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h01, '0, '0, 0);
		add_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0, 0);
		add_item(hcbp_pkg::OP_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd33, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h80, '0, '0, 0);
		// Exactly one word, then a flush of the longest partial word.
		add_item(hcbp_pkg::OP_LOAD, 8'h03, 32'h0000_0000, 6'd31, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h02, '0, '0, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0, 0);
		add_item(hcbp_pkg::OP_ENCODE, 8'h03, '0, '0, 0);
		add_item(hcbp_pkg::OP_FLUSH, 8'h00, '0, '0, 0);
		add_item(OP_UNUSED, 8'h00, '0, '0, 0);

		// Random part: load 48 random table entries, then a mix dominated by encodes of loaded symbols.
		for (int n = 0; n < 48; n++)
			add_item(hcbp_pkg::OP_LOAD, hcbp_pkg::SYM_W'($urandom_range(0, 255)), $urandom,
				draw_len(), n == 0);
		for (int n = 0; n < 760; n++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				add_item(hcbp_pkg::OP_LOAD, hcbp_pkg::SYM_W'($urandom_range(0, 255)),
					$urandom, draw_len(), n % 250 == 0);
			end else if (r < 88) begin
				if ($urandom_range(0, 99) < 85)
					s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				else
					s = hcbp_pkg::SYM_W'($urandom_range(0, 255));
				add_item(hcbp_pkg::OP_ENCODE, s, $urandom,
					hcbp_pkg::LEN_W'($urandom_range(0, 63)), n % 250 == 0);
			end else if (r < 96) begin
				add_item(hcbp_pkg::OP_FLUSH, hcbp_pkg::SYM_W'($urandom_range(0, 255)),
					$urandom, hcbp_pkg::LEN_W'($urandom_range(0, 63)), n % 250 == 0);
			end else begin
				add_item(OP_UNUSED, hcbp_pkg::SYM_W'($urandom_range(0, 255)), $urandom,
					hcbp_pkg::LEN_W'($urandom_range(0, 63)), n % 250 == 0);
			end
		end

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken != items_total)
			@(negedge clk);
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused-op items.",
			n_load, n_encode, n_flush, n_unused);
		$display("Checked %0d full words and %0d flushed partial words.", n_full, n_partial);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
rtl/hcbp_pkg.sv
rtl/huffman_code_bit_packer.sv
verif/tb_top.sv
